// ----- hw/rtl/mhpq_pkg.sv -----
package mhpq_pkg;

   localparam int DataW  = 32;
   localparam int CountW = 11;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                   command;
      logic signed [DataW-1:0]   value;
   } req_word_type;

   typedef struct packed {
      status_type                status;
      logic signed [DataW-1:0]   top_value;
      logic [CountW-1:0]         entry_count;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST_RD,
      ST_LAST_CMP,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/max_heap_priority_queue_top.sv -----
// channel | ports                          | word fields
// req     | req_valid, req_ready, req_word | command, value
// rsp     | rsp_valid, rsp_ready, rsp_word | status, top_value, entry_count
//
// One item at a time; req is free again once the result is in the output register.
// Insert climbs and remove descends at most log2(CAPACITY) levels.
// Empty remove or full insert skips the store; removing the last entry does no descent.
// Each level costs one store read round then a compare and write.
// Reset clears the state, the count and the output valid only; no clearing pass over the store.
// A result waits in the output register; a stalled rsp holds the next one.
module max_heap_priority_queue_top #(
   parameter int CAPACITY = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mhpq_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mhpq_pkg::rsp_word_type rsp_word
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr_a, rd_addr_b;
   logic signed [DataW-1:0] wr_data, rd_data_a, rd_data_b;
   logic                    res_valid, res_free;
   rsp_word_type            res_word;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff;

   mhpq_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mhpq_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .res_valid (res_valid),
      .res_free  (res_free),
      .res_word  (res_word),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign res_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res_valid && res_free) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_free) begin
         rsp_word_ff <= res_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hw/rtl/mhpq_store.sv -----
module mhpq_store #(
   parameter int CAPACITY = 1024,
   parameter int AW       = 10
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic signed [mhpq_pkg::DataW-1:0] wr_data,
   input  logic [AW-1:0]                 rd_addr_a,
   input  logic [AW-1:0]                 rd_addr_b,
   output logic signed [mhpq_pkg::DataW-1:0] rd_data_a,
   output logic signed [mhpq_pkg::DataW-1:0] rd_data_b
);
   import mhpq_pkg::*;

   logic signed [DataW-1:0] mem [CAPACITY];
   logic signed [DataW-1:0] rd_a_ff;
   logic signed [DataW-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hw/rtl/mhpq_ctrl.sv -----
module mhpq_ctrl #(
   parameter int CAPACITY = 1024,
   parameter int AW       = 10,
   parameter int CW       = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mhpq_pkg::req_word_type        req_word,
   output logic                          res_valid,
   input  logic                          res_free,
   output mhpq_pkg::rsp_word_type        res_word,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic signed [mhpq_pkg::DataW-1:0] wr_data,
   output logic [AW-1:0]                 rd_addr_a,
   output logic [AW-1:0]                 rd_addr_b,
   input  logic signed [mhpq_pkg::DataW-1:0] rd_data_a,
   input  logic signed [mhpq_pkg::DataW-1:0] rd_data_b
);
   import mhpq_pkg::*;

   localparam int IW = CW + 1;

   state_type               state_ff, state_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic signed [DataW-1:0] val_ff, val_in;
   logic signed [DataW-1:0] top_ff;
   status_type              status_ff, status_in;

   logic                    accept;
   logic                    full;
   logic [AW-1:0]           parent;
   logic [IW-1:0]           l_idx, r_idx;
   logic                    take_l, take_r;
   logic signed [DataW-1:0] cand;
   logic                    up_move;

   assign req_ready = state_ff == ST_IDLE;
   assign accept  = req_valid && req_ready;
   assign full    = fill_ff == CW'(CAPACITY);
   assign parent  = (pos_ff - AW'(1)) >> 1;
   assign l_idx   = IW'({pos_ff, 1'b1});
   assign r_idx   = l_idx + IW'(1);
   assign take_l  = (l_idx < IW'(fill_ff)) && (rd_data_a > val_ff);
   assign cand    = take_l ? rd_data_a : val_ff;
   assign take_r  = (r_idx < IW'(fill_ff)) && (rd_data_b > cand);
   assign up_move = rd_data_a < val_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.command == CMD_INSERT) begin
                  state_in = full ? ST_DONE : ST_UP_RD;
               end else begin
                  state_in = (fill_ff == '0) ? ST_DONE : ST_LAST_RD;
               end
            end
         end
         ST_LAST_RD:  state_in = ST_LAST_CMP;
         ST_LAST_CMP: state_in = (fill_ff == CW'(1)) ? ST_DONE : ST_DN_RD;
         ST_UP_RD:    state_in = (pos_ff == '0) ? ST_DONE : ST_UP_CMP;
         ST_UP_CMP:   state_in = up_move ? ST_UP_RD : ST_DONE;
         ST_DN_RD:    state_in = ST_DN_CMP;
         ST_DN_CMP:   state_in = (take_l || take_r) ? ST_DN_RD : ST_DONE;
         ST_DONE:     state_in = res_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and store access
   always_comb begin
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = val_ff;
      rd_addr_a = l_idx[AW-1:0];
      rd_addr_b = r_idx[AW-1:0];
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STATUS_OK;
               if (req_word.command == CMD_INSERT) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     pos_in  = fill_ff[AW-1:0];
                     fill_in = fill_ff + CW'(1);
                     val_in  = req_word.value;
                  end
               end else if (fill_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end
            end
         end
         ST_LAST_RD: begin
            rd_addr_a = AW'(fill_ff - CW'(1));
         end
         ST_LAST_CMP: begin
            val_in  = rd_data_a;
            fill_in = fill_ff - CW'(1);
            pos_in  = '0;
         end
         ST_UP_RD: begin
            rd_addr_a = parent;
            wr_en     = pos_ff == '0;
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (up_move) begin
               wr_data = rd_data_a;
               pos_in  = parent;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (take_r) begin
               wr_data = rd_data_b;
               pos_in  = r_idx[AW-1:0];
            end else if (take_l) begin
               wr_data = rd_data_a;
               pos_in  = l_idx[AW-1:0];
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign res_word.status      = status_ff;
   assign res_word.top_value   = (fill_ff == '0) ? '0 : top_ff;
   assign res_word.entry_count = CountW'(fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/mhpq_checker.sv -----
module mhpq_checker #(
   parameter int CAPACITY = 1024
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input mhpq_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input mhpq_pkg::rsp_word_type rsp_word
);
   import mhpq_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // one item in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while busy");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.entry_count == '0 || rsp_word.status == STATUS_EMPTY)
      |-> rsp_word.top_value == '0 && rsp_word.entry_count == '0)
      else $error("empty heap reports a value");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STATUS_FULL
      |-> rsp_word.entry_count == CountW'(CAPACITY))
      else $error("full status with spare room");

endmodule

bind max_heap_priority_queue_top mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);

// ----- dv/max_heap_priority_queue_top_tb.sv -----
module max_heap_priority_queue_top_tb;
   import mhpq_pkg::*;

   localparam int Capacity    = 1024;
   localparam int RandomItems = 700;
   localparam int StallLimit  = 4000;
   localparam int HoldCycles  = 400;
   localparam int MaxLines    = 200;

   typedef struct {
      req_word_type word;
      bit           fixed_want;
      rsp_word_type want;
   } probe_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   // predictor state
   logic signed [DataW-1:0] heap_vals [Capacity];
   int unsigned             heap_fill = 0;

   rsp_word_type  awaited_words [$];
   probe_row_type probe_rows [$];
   int            error_count = 0;
   int            rsp_seen    = 0;
   int            quiet_cycles = 0;
   bit            steady      = 1'b0;

   max_heap_priority_queue_top #(
      .CAPACITY(Capacity)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   function automatic rsp_word_type heap_apply(input req_word_type w);
      rsp_word_type            r;
      int unsigned             pos;
      int unsigned             par;
      int unsigned             kid;
      int unsigned             best;
      logic signed [DataW-1:0] t;
      r.status = STATUS_OK;
      if (w.command == CMD_INSERT) begin
         if (heap_fill >= Capacity) begin
            r.status = STATUS_FULL;
         end else begin
            heap_vals[heap_fill] = w.value;
            pos = heap_fill;
            heap_fill++;
            while (pos > 0) begin
               par = (pos - 1) / 2;
               if (heap_vals[par] >= heap_vals[pos]) break;
               t = heap_vals[par];
               heap_vals[par] = heap_vals[pos];
               heap_vals[pos] = t;
               pos = par;
            end
         end
      end else if (heap_fill == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         heap_vals[0] = heap_vals[heap_fill - 1];
         heap_fill--;
         pos = 0;
         while (pos < heap_fill) begin
            best = pos;
            kid  = 2 * pos + 1;
            if (kid < heap_fill && heap_vals[kid] > heap_vals[best]) best = kid;
            if (kid + 1 < heap_fill && heap_vals[kid + 1] > heap_vals[best]) best = kid + 1;
            if (best == pos) break;
            t = heap_vals[pos];
            heap_vals[pos] = heap_vals[best];
            heap_vals[best] = t;
            pos = best;
         end
      end
      r.top_value   = (heap_fill > 0) ? heap_vals[0] : '0;
      r.entry_count = CountW'(heap_fill);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [DataW-1:0] got,
                                  input logic [DataW-1:0] want);
      if (error_count < MaxLines)
         $display("%0t mismatch %s: got %0h, want %0h", $realtime, field, got, want);
      error_count++;
   endtask

   task automatic add_row(input cmd_type c, input logic [DataW-1:0] v, input bit fixed_want,
                          input status_type s, input logic [DataW-1:0] top, input int cnt);
      probe_row_type row;
      row.word.command     = c;
      row.word.value       = v;
      row.fixed_want       = fixed_want;
      row.want.status      = s;
      row.want.top_value   = top;
      row.want.entry_count = CountW'(cnt);
      probe_rows = {probe_rows, row};
   endtask

   function automatic logic [DataW-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 3) return 32'h7FFF_FFFF;
      if (sel < 6) return 32'h8000_0000;
      if (sel < 8) return 32'h0;
      if (sel < 10) return 32'hFFFF_FFFF;
      if (sel < 30) return DataW'($signed($urandom_range(16)) - 8);
      return $urandom;
   endfunction

   // word is driven at the falling edge and held until taken
   task automatic drive_word(input req_word_type w, input bit fixed_want,
                             input rsp_word_type want);
      rsp_word_type predicted;
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = heap_apply(w);
      awaited_words = {awaited_words, (fixed_want ? want : predicted)};
      @(negedge clock);
   endtask

   task automatic drive_random(input cmd_type c);
      req_word_type w;
      rsp_word_type unused;
      w.command = c;
      w.value   = pick_value();
      unused    = '0;
      drive_word(w, 1'b0, unused);
   endtask

   initial begin
      int unsigned lean;
      req_valid = 1'b0;
      req_word  = '0;

      add_row(CMD_REMOVE, 32'h0,         1, STATUS_EMPTY, 32'h0,         0);
      add_row(CMD_REMOVE, 32'hFFFF_FFFF, 1, STATUS_EMPTY, 32'h0,         0);
      add_row(CMD_INSERT, 32'h7FFF_FFFF, 1, STATUS_OK,    32'h7FFF_FFFF, 1);
      add_row(CMD_INSERT, 32'h8000_0000, 1, STATUS_OK,    32'h7FFF_FFFF, 2);
      add_row(CMD_REMOVE, 32'h0,         1, STATUS_OK,    32'h8000_0000, 1);
      add_row(CMD_REMOVE, 32'h0,         1, STATUS_OK,    32'h0,         0);
      add_row(CMD_REMOVE, 32'h0,         1, STATUS_EMPTY, 32'h0,         0);
      add_row(CMD_INSERT, 32'h0,         1, STATUS_OK,    32'h0,         1);
      add_row(CMD_INSERT, 32'hFFFF_FFFF, 1, STATUS_OK,    32'h0,         2);
      add_row(CMD_INSERT, 32'h1,         1, STATUS_OK,    32'h1,         3);
      add_row(CMD_INSERT, 32'h1,         1, STATUS_OK,    32'h1,         4);
      add_row(CMD_INSERT, 32'h5555_5555, 0, STATUS_OK,    32'h0,         0);
      add_row(CMD_INSERT, 32'hAAAA_AAAA, 0, STATUS_OK,    32'h0,         0);
      add_row(CMD_INSERT, 32'h8000_0000, 0, STATUS_OK,    32'h0,         0);
      add_row(CMD_INSERT, 32'h7FFF_FFFF, 0, STATUS_OK,    32'h0,         0);
      add_row(CMD_REMOVE, 32'h0,         0, STATUS_OK,    32'h0,         0);
      add_row(CMD_REMOVE, 32'h1234_5678, 0, STATUS_OK,    32'h0,         0);
      add_row(CMD_REMOVE, 32'hFFFF_FFFF, 0, STATUS_OK,    32'h0,         0);
      add_row(CMD_INSERT, 32'h7FFF_FFFE, 0, STATUS_OK,    32'h0,         0);
      for (int i = 0; i < 6; i++)
         add_row(CMD_REMOVE, 32'h0, 0, STATUS_OK, 32'h0, 0);
      add_row(CMD_REMOVE, 32'h0,         1, STATUS_EMPTY, 32'h0,         0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (probe_rows[i])
         drive_word(probe_rows[i].word, probe_rows[i].fixed_want, probe_rows[i].want);

      // mixed traffic, insert share is drawn anew every hundred words
      lean = 55;
      for (int n = 0; n < RandomItems; n++) begin
         steady = (n >= 250 && n < 400);
         if (n % 100 == 0) begin
            case ($urandom_range(2))
               0:       lean = 30;
               1:       lean = 55;
               default: lean = 80;
            endcase
         end
         drive_random(($urandom_range(99) < lean) ? CMD_INSERT : CMD_REMOVE);
      end

      // drain past empty
      while (heap_fill > 0)
         drive_random(($urandom_range(99) < 8) ? CMD_INSERT : CMD_REMOVE);
      for (int i = 0; i < 3; i++) drive_random(CMD_REMOVE);

      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // receiver, with one long hold-off to back the block up
   initial begin
      bit held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_seen >= 100) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         rsp_ready <= steady || ($urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (awaited_words.size() == 0) begin
            report_mismatch("unexpected word", DataW'(rsp_word.top_value), '0);
         end else begin
            want = awaited_words.pop_front();
            if (rsp_word.status !== want.status)
               report_mismatch("status", DataW'(rsp_word.status), DataW'(want.status));
            if (rsp_word.top_value !== want.top_value)
               report_mismatch("top_value", rsp_word.top_value, want.top_value);
            if (rsp_word.entry_count !== want.entry_count)
               report_mismatch("entry_count", DataW'(rsp_word.entry_count),
                               DataW'(want.entry_count));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
